// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/b64codec_pkg.sv -----
// ----------------------------------------------------------------------------
// b64codec_pkg
// Shared types, character codes and alphabet mapping functions of the stream codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64codec_pkg;

  localparam int BITS_W      = 12;
  localparam int CNT_W       = 4;
  localparam int GRP_W       = 3;
  localparam int RES_CNT_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // base_select codes
  localparam logic [1:0] BASE_64 = 2'd0;
  localparam logic [1:0] BASE_32 = 2'd1;
  localparam logic [1:0] BASE_16 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_DIR  = 2'd1;
  localparam logic [1:0] REG_SKIP = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_PAD    = 8'h3D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] ASCII_MAX = 8'd127;

  typedef enum logic [1:0] {
    CLS_SYM,
    CLS_BAD,
    CLS_STOP,
    CLS_SKIP
  } cls_t;

  typedef struct packed {
    logic [7:0] chr;
    logic [5:0] sym;
    cls_t       cls;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] base;
    logic       dir;
    logic       skip_nl;
  } cfg_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] sym;
  } dsym_t;

  function automatic logic [CNT_W-1:0] sym_width(input logic [1:0] base);
    case (base)
      BASE_64: sym_width = CNT_W'(6);
      BASE_32: sym_width = CNT_W'(5);
      default: sym_width = CNT_W'(4);
    endcase
  endfunction

  // low bits of the symbol counter that must be zero at the end of a group
  function automatic logic [GRP_W-1:0] pad_mask(input logic [1:0] base);
    case (base)
      BASE_64: pad_mask = 3'b011;
      BASE_32: pad_mask = 3'b111;
      default: pad_mask = 3'b000;
    endcase
  endfunction

  function automatic logic [7:0] enc_char(input logic [1:0] base, input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    case (base)
      BASE_64: begin
        if (v8 < 8'd26)      enc_char = CH_UA + v8;
        else if (v8 < 8'd52) enc_char = CH_LA + v8 - 8'd26;
        else if (v8 < 8'd62) enc_char = CH_0 + v8 - 8'd52;
        else if (v8 == 8'd62) enc_char = CH_PLUS;
        else                 enc_char = CH_SLASH;
      end
      BASE_32: enc_char = (v8 < 8'd26) ? CH_UA + v8 : CH_2 + v8 - 8'd26;
      default: enc_char = (v8 < 8'd10) ? CH_0 + v8 : CH_UA + v8 - 8'd10;
    endcase
  endfunction

  function automatic dsym_t dec_char(input logic [1:0] base, input logic [7:0] c);
    dsym_t      r;
    logic [7:0] s;
    r.bad = 1'b1;
    s     = 8'd0;
    if (c <= ASCII_MAX) begin
      case (base)
        BASE_64: begin
          if (c >= CH_UA && c <= CH_UZ) begin
            s = c - CH_UA; r.bad = 1'b0;
          end else if (c >= CH_LA && c <= CH_LZ) begin
            s = c - CH_LA + 8'd26; r.bad = 1'b0;
          end else if (c >= CH_0 && c <= CH_9) begin
            s = c - CH_0 + 8'd52; r.bad = 1'b0;
          end else if (c == CH_PLUS) begin
            s = 8'd62; r.bad = 1'b0;
          end else if (c == CH_SLASH) begin
            s = 8'd63; r.bad = 1'b0;
          end
        end
        BASE_32: begin
          if (c >= CH_UA && c <= CH_UZ) begin
            s = c - CH_UA; r.bad = 1'b0;
          end else if (c >= CH_2 && c <= CH_7) begin
            s = c - CH_2 + 8'd26; r.bad = 1'b0;
          end
        end
        default: begin
          if (c >= CH_0 && c <= CH_9) begin
            s = c - CH_0; r.bad = 1'b0;
          end else if (c >= CH_UA && c <= CH_UF) begin
            s = c - CH_UA + 8'd10; r.bad = 1'b0;
          end else if (c >= CH_LA && c <= CH_LF_F) begin
            s = c - CH_LA + 8'd10; r.bad = 1'b0;
          end
        end
      endcase
    end
    r.sym = s[5:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/base16_32_64_stream_codec_core.sv -----
// ----------------------------------------------------------------------------
// base16_32_64_stream_codec_core - base64/base32/base16 stream encoder and decoder
// An input transaction passes through the command queue and the output register.
// Throughput: one result per cycle from the bit engine unless the output stalls;
//   an item is held until its results are out (two per byte in base16 encode).
// Reset: synchronous active-low rst_n clears config, queue and engine state.
// ----------------------------------------------------------------------------
`default_nettype none

module base16_32_64_stream_codec_core
  import b64codec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data
  output logic [1:0]      out_tuser,  // [0] data_valid, [1] error
  output logic            out_tlast
);

  cfg_t cfg_r;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE: cfg_r.base    <= cfg_wdata;
        REG_DIR:  cfg_r.dir     <= cfg_wdata[0];
        REG_SKIP: cfg_r.skip_nl <= cfg_wdata[0];
        default:  cfg_r         <= cfg_r;
      endcase
    end
  end

  b64codec_front u_front (
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  b64codec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_cmd    (push_cmd),
    .pop       (q_pop),
    .rd_cmd    (head_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  b64codec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head_cmd),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- sv/b64codec_front.sv -----
// ----------------------------------------------------------------------------
// b64codec_front
// Input side: takes a character transaction and classifies it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64codec_front
  import b64codec_pkg::*;
(
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic       in_tlast,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire cfg_t       cfg,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  dsym_t dec;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    dec        = dec_char(cfg.base, in_tdata);
    q_cmd.chr  = in_tdata;
    q_cmd.sym  = dec.sym;
    q_cmd.last = in_tlast;
    // order matters: terminators win over newline skipping, which wins over lookup
    if (in_tdata == CH_NUL || in_tdata == CH_PAD) begin
      q_cmd.cls = CLS_STOP;
    end else if (in_tdata == CH_LF && cfg.skip_nl) begin
      q_cmd.cls = CLS_SKIP;
    end else if (dec.bad) begin
      q_cmd.cls = CLS_BAD;
    end else begin
      q_cmd.cls = CLS_SYM;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b64codec_queue.sv -----
// ----------------------------------------------------------------------------
// b64codec_queue
// Small command FIFO between the classifier and the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module b64codec_queue
  import b64codec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      full,
  output logic      not_empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

`default_nettype wire

// ----- sv/b64codec_back.sv -----
// ----------------------------------------------------------------------------
// b64codec_back
// Bit accumulator engine: runs one queued command, one result per cycle while
// the receiver does not stall the output register, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64codec_back
  import b64codec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire cmd_t       head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] data
  output logic [1:0]      out_tuser,   // [0] data_valid, [1] error
  output logic            out_tlast
);

  logic [BITS_W-1:0]    bits_r, bits_nxt, bits_s, ext;
  logic [CNT_W-1:0]     nbits_r, nbits_nxt, nbits_s;
  logic [GRP_W-1:0]     grp_r, grp_nxt;
  logic                 err_r, err_nxt, err_s;
  logic                 term_r, term_nxt, term_s;
  logic                 tail_r, tail_s;
  logic                 started_r;
  logic [RES_CNT_W-1:0] rc_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic                 out_dv_r, out_err_r, out_eom_r;

  logic [CNT_W-1:0]     wsym, wsel, add_n;
  logic [CNT_W:0]       sum;
  logic [GRP_W-1:0]     pmask;
  logic [5:0]           sym_v;
  logic                 take, flush, pad, emit, more, cap, done;
  logic                 step, can_load, out_load;
  logic [7:0]           data;

  always_comb begin
    wsym  = sym_width(cfg.base);
    wsel  = cfg.dir ? CNT_W'(8) : wsym;
    pmask = pad_mask(cfg.base);

    // first cycle of a command folds in its push
    bits_s = bits_r;
    nbits_s = nbits_r;
    err_s  = err_r;
    term_s = term_r;
    tail_s = tail_r;
    add_n  = '0;
    if (!started_r) begin
      tail_s = 1'b0;
      if (!cfg.dir) begin
        bits_s = {bits_r[3:0], head.chr};
        add_n  = CNT_W'(8);
        tail_s = head.last;
      end else if (!term_r) begin
        unique case (head.cls)
          CLS_STOP: begin
            tail_s = 1'b1;
            term_s = 1'b1;
          end
          CLS_SKIP: tail_s = head.last;
          CLS_BAD: begin
            err_s   = 1'b1;
            term_s  = 1'b1;
            bits_s  = '0;
            nbits_s = '0;
          end
          CLS_SYM: begin
            case (cfg.base)
              BASE_64: bits_s = {bits_r[5:0], head.sym};
              BASE_32: bits_s = {bits_r[6:0], head.sym[4:0]};
              default: bits_s = {bits_r[7:0], head.sym[3:0]};
            endcase
            add_n  = wsym;
            tail_s = head.last;
          end
        endcase
      end
    end
    // saturate at the buffer size; older bits fall off the top
    sum = {1'b0, nbits_s} + {1'b0, add_n};
    if (sum > (CNT_W+1)'(BITS_W)) nbits_s = CNT_W'(BITS_W);
    else                          nbits_s = sum[CNT_W-1:0];

    take  = (nbits_s >= wsel);
    flush = !take && tail_s && (nbits_s != '0);
    pad   = !cfg.dir && !take && !flush && tail_s && ((grp_r & pmask) != '0);
    emit  = take || flush || pad;
    // leftover bits go out left-aligned
    ext   = take ? (bits_s >> (nbits_s - wsel)) : (bits_s << (wsel - nbits_s));
    sym_v = ext[5:0] & ~(6'h3F << wsym);

    if (pad)           data = CH_PAD;
    else if (!emit)    data = CH_NUL;
    else if (cfg.dir)  data = ext[7:0];
    else               data = enc_char(cfg.base, sym_v);

    bits_nxt  = bits_s;
    nbits_nxt = take ? (nbits_s - wsel) : (flush ? '0 : nbits_s);
    grp_nxt   = (!cfg.dir && emit) ? grp_r + GRP_W'(1) : grp_r;
    err_nxt   = err_s;
    term_nxt  = term_s;

    more = (nbits_nxt >= wsel) ||
           (tail_s && ((nbits_nxt != '0) || (!cfg.dir && ((grp_nxt & pmask) != '0))));
    // the last item of a message gives at most eight results; the eighth closes the message
    cap  = head.last && (rc_r == '1);
    done = !emit || !more || cap;

    can_load = !out_valid_r || out_tready;
    step     = head_valid && can_load;
    out_load = step && (emit || head.last);
    pop      = step && done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      nbits_r     <= '0;
      grp_r       <= '0;
      err_r       <= 1'b0;
      term_r      <= 1'b0;
      tail_r      <= 1'b0;
      started_r   <= 1'b0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        if (done && head.last) begin
          bits_r  <= '0;
          nbits_r <= '0;
          grp_r   <= '0;
          err_r   <= 1'b0;
          term_r  <= 1'b0;
        end else begin
          bits_r  <= bits_nxt;
          nbits_r <= nbits_nxt;
          grp_r   <= grp_nxt;
          err_r   <= err_nxt;
          term_r  <= term_nxt;
        end
        tail_r    <= tail_s;
        started_r <= !done;
        rc_r      <= done ? '0 : rc_r + RES_CNT_W'(1);
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= data;
      out_dv_r   <= emit;
      out_err_r  <= err_s;
      out_eom_r  <= head.last && done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_err_r, out_dv_r};
  assign out_tlast  = out_eom_r;

endmodule

`default_nettype wire

// ----- sv/b64codec_checker.sv -----
// ----------------------------------------------------------------------------
// b64codec_checker
// Port-level checks of the codec output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module b64codec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);

  // an empty marker only ever closes a message
  `ASSERT_RST(a_marker_is_end, clk, rst_n, (out_tvalid && !out_tuser[0]) |-> out_tlast, "marker without end_of_message")

  `ASSERT_RST(a_marker_zero, clk, rst_n, (out_tvalid && !out_tuser[0]) |-> (out_tdata == 8'd0), "marker carries nonzero data")

  `ASSERT_RST(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)), "stalled result changed")

  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind base16_32_64_stream_codec_core b64codec_checker u_b64codec_checker (.*);

`default_nettype wire

// ----- bench/tb_base16_32_64_stream_codec_core.sv -----
// ----------------------------------------------------------------------------
// tb_base16_32_64_stream_codec_core
// Self-checking bench for the base64/base32/base16 stream codec. A scoreboard
// class predicts every result from each accepted input transaction. Its model
// follows the bit accumulator, padding, termination and sticky error rules.
// Directed messages come first. Random encode and decode messages follow, with
// bursty input traffic, output back-pressure and config changes between
// phases, some of them in the middle of a message.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import b64codec_pkg::*;

typedef struct packed {
  logic [7:0] data;
  logic       data_valid;
  logic       error;
  logic       eom;
} codec_result_t;

class codec_scoreboard;
  localparam int MAX_STEP_RESULTS = 8;

  string alpha64 = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string alpha32 = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  string alpha16 = "0123456789ABCDEF";

  logic [1:0]  base;
  logic        decoding;
  logic        skip_lf;
  logic [11:0] acc_bits;
  logic [3:0]  acc_cnt;
  logic [2:0]  grp_cnt;
  logic        err_seen;
  logic        stopped;

  codec_result_t expected_results[$];
  codec_result_t step_results[$];
  int failures;

  function new();
    base     = BASE_64;
    decoding = 1'b0;
    skip_lf  = 1'b0;
    failures = 0;
    clear_message();
  endfunction

  function void clear_message();
    acc_bits = '0;
    acc_cnt  = '0;
    grp_cnt  = '0;
    err_seen = 1'b0;
    stopped  = 1'b0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [1:0] val);
    case (idx)
      REG_BASE: base     = val;
      REG_DIR:  decoding = val[0];
      REG_SKIP: skip_lf  = val[0];
      default: ;
    endcase
  endfunction

  function int unsigned sym_bits();
    return (base == BASE_64) ? 6 : ((base == BASE_32) ? 5 : 4);
  endfunction

  function int unsigned group_chars();
    return (base == BASE_64) ? 4 : ((base == BASE_32) ? 8 : 0);
  endfunction

  function string alphabet();
    case (base)
      BASE_64: return alpha64;
      BASE_32: return alpha32;
      default: return alpha16;
    endcase
  endfunction

  function logic [7:0] to_char(int unsigned v);
    string a;
    a = alphabet();
    return a[v];
  endfunction

  function int from_char(logic [7:0] c);
    string      a;
    logic [7:0] k;
    int         i;
    k = c;
    if (c > ASCII_MAX) return -1;
    a = alphabet();
    // hex digits are accepted in either case
    if (base != BASE_64 && base != BASE_32 && k >= CH_LA && k <= CH_LF_F) k = k - 8'h20;
    for (i = 0; i < a.len(); i++)
      if (a[i] == k) return i;
    return -1;
  endfunction

  function void push_bits(int unsigned v, int unsigned n);
    int unsigned t;
    t        = (int'(acc_bits) << n) | v;
    acc_bits = t[11:0];
    t        = acc_cnt + n;
    acc_cnt  = (t > 12) ? 4'd12 : t[3:0];
  endfunction

  function int unsigned pull_bits(int unsigned w);
    int unsigned b, c, v;
    b        = acc_bits;
    c        = acc_cnt;
    v        = (b >> (c - w)) & ((1 << w) - 1);
    c        = c - w;
    b        = b & ((1 << c) - 1);
    acc_bits = b[11:0];
    acc_cnt  = c[3:0];
    return v;
  endfunction

  function void emit(int unsigned d, logic dv);
    codec_result_t r;
    if (step_results.size() >= MAX_STEP_RESULTS) return;
    r.data       = d[7:0];
    r.data_valid = dv;
    r.error      = 1'b0;
    r.eom        = 1'b0;
    step_results.push_back(r);
  endfunction

  function void flush_bytes();
    int unsigned b;
    while (acc_cnt >= 8) emit(pull_bits(8), 1'b1);
    if (acc_cnt > 0) begin
      b = acc_bits;
      emit((b << (8 - acc_cnt)) & 8'hFF, 1'b1);
    end
    acc_bits = '0;
    acc_cnt  = '0;
  endfunction

  function void encode_byte(logic [7:0] c, logic l);
    int unsigned w, g, b, pad;
    w = sym_bits();
    g = group_chars();
    push_bits(c, 8);
    while (acc_cnt >= w) begin
      emit(to_char(pull_bits(w)), 1'b1);
      grp_cnt = grp_cnt + 3'd1;
    end
    if (!l) return;
    if (acc_cnt > 0) begin
      // leftover bits, zero-filled on the right
      b = acc_bits;
      emit(to_char((b << (w - acc_cnt)) & ((1 << w) - 1)), 1'b1);
      grp_cnt = grp_cnt + 3'd1;
    end
    if (g != 0) begin
      pad = (g - (grp_cnt & (g - 1))) & (g - 1);
      repeat (pad) emit(CH_PAD, 1'b1);
    end
  endfunction

  function void decode_char(logic [7:0] c, logic l);
    int v;
    if (stopped) return;
    if (c == CH_NUL || c == CH_PAD) begin
      flush_bytes();
      stopped = 1'b1;
      return;
    end
    if (!(c == CH_LF && skip_lf)) begin
      v = from_char(c);
      if (v < 0) begin
        err_seen = 1'b1;
        stopped  = 1'b1;
        acc_bits = '0;
        acc_cnt  = '0;
        return;
      end
      push_bits(v, sym_bits());
      while (acc_cnt >= 8) emit(pull_bits(8), 1'b1);
    end
    if (l) flush_bytes();
  endfunction

  // called for every accepted input transaction
  function void note_input(logic [7:0] c, logic l);
    int i;
    step_results.delete();
    if (decoding) decode_char(c, l);
    else encode_byte(c, l);
    if (l) begin
      if (step_results.size() == 0) emit(0, 1'b0);
      step_results[step_results.size() - 1].eom = 1'b1;
    end
    for (i = 0; i < step_results.size(); i++) begin
      step_results[i].error = err_seen;
      expected_results.push_back(step_results[i]);
    end
    if (l) clear_message();
  endfunction

  // called for every accepted output transaction
  function void check_result(logic [7:0] d, logic [1:0] u, logic l);
    codec_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: data=%h tuser=%b tlast=%b", d, u, l);
      failures++;
      return;
    end
    e = expected_results.pop_front();
    if (d !== e.data) begin
      $error("data mismatch: expected %h, actual %h", e.data, d);
      failures++;
    end
    if (u[0] !== e.data_valid) begin
      $error("data_valid mismatch: expected %b, actual %b", e.data_valid, u[0]);
      failures++;
    end
    if (u[1] !== e.error) begin
      $error("error mismatch: expected %b, actual %b", e.error, u[1]);
      failures++;
    end
    if (l !== e.eom) begin
      $error("end_of_message mismatch: expected %b, actual %b", e.eom, l);
      failures++;
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_base16_32_64_stream_codec_core;

  localparam int CYCLE_LIMIT    = 300000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 185;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [1:0] cfg_wdata = '0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;  // [7:0] char_in
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;      // [7:0] data
  logic [1:0] out_tuser;      // [0] data_valid, [1] error
  logic       out_tlast;

  codec_scoreboard sb = new();

  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int unsigned stall_mode = 0;
  logic [1:0]  cur_base = BASE_64;
  logic        cur_dir = 1'b0;
  logic        cur_skip = 1'b0;

  base16_32_64_stream_codec_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit and receiver back-pressure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (cycle_count % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // one input transaction; the sender may idle between bursts
  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] b, input logic d, input logic s);
    cur_base  = b;
    cur_dir   = d;
    cur_skip  = s;
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_wdata <= b;
    @(posedge clk);
    sb.write_reg(REG_BASE, b);
    cfg_index <= REG_DIR;
    cfg_wdata <= {1'b0, d};
    @(posedge clk);
    sb.write_reg(REG_DIR, {1'b0, d});
    cfg_index <= REG_SKIP;
    cfg_wdata <= {1'b0, s};
    @(posedge clk);
    sb.write_reg(REG_SKIP, {1'b0, s});
    cfg_we    <= 1'b0;
  endtask

  task automatic send_raw_message(input bit open_end);
    int         len, i;
    logic [7:0] c;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: c = 8'h00;
        1: c = 8'hFF;
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_char(c, (i == len - 1) && !open_end);
    end
  endtask

  // mostly clean text in the current alphabet, some of it noisy
  task automatic send_text_message(input bit open_end);
    int         len, i;
    bit         noisy;
    logic [7:0] c;
    len   = $urandom_range(1, 16);
    noisy = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: c = CH_LF;
          1: c = CH_PAD;
          2: c = CH_NUL;
          default: c = 8'($urandom_range(0, 255));
        endcase
      end else if (cur_skip && $urandom_range(0, 7) == 0) begin
        c = CH_LF;
      end else if (i == len - 1 && $urandom_range(0, 2) == 0) begin
        c = CH_PAD;
      end else begin
        c = sb.to_char($urandom_range(0, (1 << sb.sym_bits()) - 1));
        if (cur_base[1] && c >= CH_UA && c <= CH_UF && $urandom_range(0, 1))
          c = c + 8'h20;
      end
      send_char(c, (i == len - 1) && !open_end);
    end
  endtask

  initial begin
    int  msgs, m;
    bit  open_end;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode: byte extremes, padding for base64 and base32, base_select 3
    write_config(BASE_64, 1'b0, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);
    send_char(8'hFF, 1'b1);
    drain_outputs();
    write_config(BASE_32, 1'b0, 1'b0);
    send_char(8'h5A, 1'b1);
    drain_outputs();
    write_config(2'd3, 1'b0, 1'b0);
    send_char(8'hA5, 1'b1);
    drain_outputs();

    // decode: skipped newline, pad stop, ignored tail, marker on last
    write_config(BASE_64, 1'b1, 1'b1);
    send_char("T", 1'b0);
    send_char("W", 1'b0);
    send_char(CH_LF, 1'b0);
    send_char("E", 1'b0);
    send_char(CH_PAD, 1'b0);
    send_char("Q", 1'b0);
    send_char("x", 1'b1);
    drain_outputs();
    // newline not skipped: sticky error
    write_config(BASE_64, 1'b1, 1'b0);
    send_char("A", 1'b0);
    send_char(CH_LF, 1'b1);
    drain_outputs();
    // character above the ASCII range
    write_config(BASE_32, 1'b1, 1'b0);
    send_char("M", 1'b0);
    send_char(8'h80, 1'b1);
    drain_outputs();
    // mixed-case hex, zero byte stop
    write_config(BASE_16, 1'b1, 1'b0);
    send_char("f", 1'b0);
    send_char("F", 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char("1", 1'b1);
    drain_outputs();

    // mode changes inside a message, including accumulator saturation
    write_config(BASE_64, 1'b0, 1'b0);
    send_char(8'hAB, 1'b0);
    drain_outputs();
    write_config(BASE_16, 1'b1, 1'b0);
    send_char("7", 1'b1);
    drain_outputs();
    write_config(BASE_32, 1'b1, 1'b0);
    send_char("7", 1'b0);
    drain_outputs();
    write_config(BASE_16, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1);
    drain_outputs();

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      write_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      msgs = $urandom_range(1, 4);
      for (m = 0; m < msgs; m++) begin
        // now and then leave the message open across the next config change
        open_end = (m == msgs - 1) && ($urandom_range(0, 9) == 0);
        if (cur_dir) send_text_message(open_end);
        else send_raw_message(open_end);
      end
      drain_outputs();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
